[src/mgfw_pkg.sv]
// Package for the monochrome glyph framebuffer writer.
// Holds request/result payload types, codes, and controller/datapath types.
// No dependencies.
package mgfw_pkg;

    localparam int CFG_AW       = 4;
    localparam int FRAME_IDX_W  = 14;
    localparam int GLYPH_ADDR_W = 17;

    localparam logic [2:0] REQ_FONT_WR = 3'd0;
    localparam logic [2:0] REQ_CURSOR  = 3'd1;
    localparam logic [2:0] REQ_CHAR    = 3'd2;
    localparam logic [2:0] REQ_PIXEL   = 3'd3;
    localparam logic [2:0] REQ_FILL    = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    localparam logic [1:0] REG_FONT_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FONT_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CYRILLIC_BASE = 2'd2;

    localparam logic [4:0]  FONT_WIDTH_RST    = 5'd7;
    localparam logic [5:0]  FONT_HEIGHT_RST   = 6'd10;
    localparam logic [11:0] CYRILLIC_BASE_RST = 12'd2048;

    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_DEL   = 8'd127;
    localparam logic [7:0] CHAR_CYR   = 8'd192;
    localparam logic [7:0] CURSOR_MAX = 8'hFF;
    localparam logic [4:0] ROW_BITS   = 5'd16;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] addr;
        logic [15:0] font_word;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  char_code;
        logic        ink;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] cursor_col;
    } res_t;

    typedef struct packed {
        logic [4:0]  font_width;
        logic [5:0]  font_height;
        logic [11:0] cyrillic_base;
    } cfg_t;

    typedef enum logic [1:0] {
        FSEL_SWEEP,
        FSEL_PIXEL,
        FSEL_CHAR,
        FSEL_READ
    } frame_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FONT,
        ST_CURSOR,
        ST_FILL,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_BYTE_RD,
        ST_BYTE_CAP,
        ST_CH_START,
        ST_GLYPH_RD,
        ST_GLYPH_CAP,
        ST_CH_RD,
        ST_CH_WR,
        ST_CH_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        frame_sel_t frame_sel;
        logic       frame_we;
        logic       sweep_step;
        logic       sweep_clear;
        logic       glyph_we;
        logic       cursor_set;
        logic       cursor_advance;
        logic       char_init;
        logic       row_capture;
        logic       col_step;
        logic       row_step;
        logic       read_capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic draw_ok;
        logic last_col;
        logic last_row;
        logic sweep_last;
    } dp_stat_t;

endpackage

[src/mgfw_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mgfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/mgfw_cfg.sv]
// APB-style configuration registers: font width, font height, cyrillic base.
// Depends on mgfw_pkg.
module mgfw_cfg import mgfw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.font_width    <= FONT_WIDTH_RST;
            cfg_reg.font_height   <= FONT_HEIGHT_RST;
            cfg_reg.cyrillic_base <= CYRILLIC_BASE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FONT_WIDTH:    cfg_reg.font_width    <= pwdata[4:0];
                REG_FONT_HEIGHT:   cfg_reg.font_height   <= pwdata[5:0];
                REG_CYRILLIC_BASE: cfg_reg.cyrillic_base <= pwdata[11:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FONT_WIDTH:    prdata = {27'd0, cfg_reg.font_width};
            REG_FONT_HEIGHT:   prdata = {26'd0, cfg_reg.font_height};
            REG_CYRILLIC_BASE: prdata = {20'd0, cfg_reg.cyrillic_base};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[src/mgfw_ctrl.sv]
// Controller state machine: sequences requests and issues datapath commands.
// Depends on mgfw_pkg.
module mgfw_ctrl import mgfw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] req_type,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_FONT_WR: state_next = ST_FONT;
                        REQ_CURSOR:  state_next = ST_CURSOR;
                        REQ_CHAR:    state_next = ST_CH_START;
                        REQ_PIXEL:   state_next = ST_PIX_RD;
                        REQ_FILL:    state_next = ST_FILL;
                        REQ_READ:    state_next = ST_BYTE_RD;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_FONT:      state_next = ST_DONE;
            ST_CURSOR:    state_next = ST_DONE;
            ST_FILL:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PIX_RD:    state_next = ST_PIX_WR;
            ST_PIX_WR:    state_next = ST_DONE;
            ST_BYTE_RD:   state_next = ST_BYTE_CAP;
            ST_BYTE_CAP:  state_next = ST_DONE;
            ST_CH_START:  state_next = stat.draw_ok ? ST_GLYPH_RD : ST_CH_END;
            ST_GLYPH_RD:  state_next = ST_GLYPH_CAP;
            ST_GLYPH_CAP: state_next = ST_CH_RD;
            ST_CH_RD:     state_next = ST_CH_WR;
            ST_CH_WR:
            begin
                if (!stat.last_col)
                begin
                    state_next = ST_CH_RD;
                end
                else if (stat.last_row)
                begin
                    state_next = ST_CH_END;
                end
                else
                begin
                    state_next = ST_GLYPH_RD;
                end
            end
            ST_CH_END:    state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.frame_sel = FSEL_SWEEP;
        busy      = 1'b1;
        done      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.frame_we    = 1'b1;
                cmd.sweep_step  = 1'b1;
                cmd.sweep_clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_FONT:      cmd.glyph_we = 1'b1;
            ST_CURSOR:    cmd.cursor_set = 1'b1;
            ST_FILL:
            begin
                cmd.frame_we   = 1'b1;
                cmd.sweep_step = 1'b1;
            end
            ST_PIX_RD:    cmd.frame_sel = FSEL_PIXEL;
            ST_PIX_WR:
            begin
                cmd.frame_sel = FSEL_PIXEL;
                cmd.frame_we  = 1'b1;
            end
            ST_BYTE_RD:   cmd.frame_sel = FSEL_READ;
            ST_BYTE_CAP:
            begin
                cmd.frame_sel    = FSEL_READ;
                cmd.read_capture = 1'b1;
            end
            ST_CH_START:  cmd.char_init = 1'b1;
            ST_GLYPH_RD:  cmd.frame_sel = FSEL_CHAR;
            ST_GLYPH_CAP:
            begin
                cmd.frame_sel   = FSEL_CHAR;
                cmd.row_capture = 1'b1;
            end
            ST_CH_RD:     cmd.frame_sel = FSEL_CHAR;
            ST_CH_WR:
            begin
                cmd.frame_sel = FSEL_CHAR;
                cmd.frame_we  = 1'b1;
                cmd.col_step  = !stat.last_col;
                cmd.row_step  = stat.last_col & !stat.last_row;
            end
            ST_CH_END:    cmd.cursor_advance = 1'b1;
            ST_DONE:      done = 1'b1;
            default:      ;
        endcase
    end

endmodule

[src/mgfw_dp.sv]
// Datapath: request latch, cursor, glyph row walk, frame and font memories.
// Depends on mgfw_pkg and mgfw_ram.
module mgfw_dp import mgfw_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int GLYPH_DEPTH   = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req,
    input  cfg_t      cfg,
    input  ctrl_cmd_t cmd,
    output dp_stat_t  stat,
    output res_t      res
);

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int FAW         = $clog2(FRAME_BYTES);
    localparam int GAW         = $clog2(GLYPH_DEPTH);

    req_t                    req_reg;
    logic [7:0]              cursor_x_reg;
    logic [7:0]              cursor_y_reg;
    logic [15:0]             row_reg;
    logic [4:0]              col_reg;
    logic [5:0]              line_reg;
    logic [FRAME_IDX_W-1:0]  gaddr_reg;
    logic [FAW-1:0]          sweep_reg;
    logic [7:0]              rd_reg;

    logic                    fit_x;
    logic                    fit_y;
    logic                    is_latin;
    logic                    is_cyr;
    logic [6:0]              latin_ofs;
    logic [5:0]              cyr_ofs;
    logic [FRAME_IDX_W-1:0]  latin_base;
    logic [FRAME_IDX_W-1:0]  cyr_base;
    logic [FRAME_IDX_W-1:0]  glyph_base;
    logic [8:0]              adv_sum;
    logic                    char_mode;
    logic [8:0]              pix_x;
    logic [8:0]              pix_y;
    logic                    pix_on;
    logic [4:0]              page;
    logic [FRAME_IDX_W-1:0]  pix_idx;
    logic [FRAME_IDX_W-1:0]  rd_idx;
    logic                    rd_on;
    logic [4:0]              bit_sh;
    logic                    font_bit;
    logic                    colour;
    logic [7:0]              bit_mask;
    logic [FAW-1:0]          f_addr;
    logic                    f_we;
    logic [7:0]              f_wdata;
    logic [7:0]              f_q;
    logic [GLYPH_ADDR_W-1:0] g_rd_ext;
    logic [GLYPH_ADDR_W-1:0] g_wr_ext;
    logic                    g_rd_on;
    logic                    g_wr_on;
    logic [15:0]             g_q;

    assign fit_x = ({1'b0, cursor_x_reg} + {4'd0, cfg.font_width}) < 9'(SCREEN_WIDTH);
    assign fit_y = ({1'b0, cursor_y_reg} + {3'd0, cfg.font_height}) < 9'(SCREEN_HEIGHT);

    assign is_latin = (req_reg.char_code >= CHAR_FIRST) && (req_reg.char_code < CHAR_DEL);
    assign is_cyr   = req_reg.char_code >= CHAR_CYR;
    assign latin_ofs = 7'(req_reg.char_code - CHAR_FIRST);
    assign cyr_ofs   = 6'(req_reg.char_code - CHAR_CYR);
    assign latin_base = {7'd0, latin_ofs} * {8'd0, cfg.font_height};
    assign cyr_base   = FRAME_IDX_W'(cfg.cyrillic_base)
                      + ({8'd0, cyr_ofs} * {8'd0, cfg.font_height});
    assign glyph_base = is_cyr ? cyr_base : latin_base;

    assign adv_sum = {1'b0, cursor_x_reg} + {4'd0, cfg.font_width};

    assign stat.draw_ok    = (is_latin | is_cyr) & fit_x & fit_y
                           & (cfg.font_width != 5'd0) & (cfg.font_height != 6'd0);
    assign stat.last_col   = ({1'b0, col_reg} + 6'd1) == {1'b0, cfg.font_width};
    assign stat.last_row   = ({1'b0, line_reg} + 7'd1) == {1'b0, cfg.font_height};
    assign stat.sweep_last = sweep_reg == FAW'(FRAME_BYTES - 1);

    // pixel address: byte x + page * width, bit y % 8
    assign char_mode = cmd.frame_sel == FSEL_CHAR;
    assign pix_x = char_mode ? ({1'b0, cursor_x_reg} + {4'd0, col_reg})
                             : {1'b0, req_reg.pos_x};
    assign pix_y = char_mode ? ({1'b0, cursor_y_reg} + {3'd0, line_reg})
                             : {1'b0, req_reg.pos_y};
    assign pix_on  = (pix_x < 9'(SCREEN_WIDTH)) && (pix_y < 9'(SCREEN_HEIGHT));
    assign page    = pix_y[7:3];
    assign pix_idx = FRAME_IDX_W'(pix_x)
                   + ({9'd0, page} * FRAME_IDX_W'(SCREEN_WIDTH));
    assign rd_idx  = FRAME_IDX_W'(req_reg.addr);
    assign rd_on   = rd_idx < FRAME_IDX_W'(FRAME_BYTES);

    // leftmost column takes bit font_width-1; bits past 15 are clear
    assign bit_sh   = cfg.font_width - 5'd1 - col_reg;
    assign font_bit = (bit_sh < ROW_BITS) ? row_reg[bit_sh[3:0]] : 1'b0;
    assign colour   = char_mode ? (font_bit ? req_reg.ink : ~req_reg.ink) : req_reg.ink;
    assign bit_mask = 8'd1 << pix_y[2:0];

    always_comb
    begin
        case (cmd.frame_sel)
            FSEL_SWEEP: f_addr = sweep_reg;
            FSEL_PIXEL: f_addr = pix_idx[FAW-1:0];
            FSEL_CHAR:  f_addr = pix_idx[FAW-1:0];
            FSEL_READ:  f_addr = rd_idx[FAW-1:0];
            default:    f_addr = sweep_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.frame_sel == FSEL_SWEEP)
        begin
            f_wdata = cmd.sweep_clear ? 8'h00 : {8{req_reg.ink}};
        end
        else if (colour)
        begin
            f_wdata = f_q | bit_mask;
        end
        else
        begin
            f_wdata = f_q & ~bit_mask;
        end
    end

    assign f_we = cmd.frame_we & ((cmd.frame_sel != FSEL_PIXEL) | pix_on);

    assign g_rd_ext = GLYPH_ADDR_W'(gaddr_reg);
    assign g_wr_ext = GLYPH_ADDR_W'(req_reg.addr);
    assign g_rd_on  = g_rd_ext < GLYPH_ADDR_W'(GLYPH_DEPTH);
    assign g_wr_on  = g_wr_ext < GLYPH_ADDR_W'(GLYPH_DEPTH);

    mgfw_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_addr),
        .wdata (f_wdata),
        .raddr (f_addr),
        .rdata (f_q)
    );

    mgfw_ram #(
        .WIDTH (16),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (cmd.glyph_we & g_wr_on),
        .waddr (g_wr_ext[GAW-1:0]),
        .wdata (req_reg.font_word),
        .raddr (g_rd_ext[GAW-1:0]),
        .rdata (g_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= 8'd0;
            cursor_y_reg <= 8'd0;
            sweep_reg    <= '0;
        end
        else
        begin
            if (cmd.cursor_set)
            begin
                cursor_x_reg <= req_reg.pos_x;
                cursor_y_reg <= req_reg.pos_y;
            end
            else if (cmd.cursor_advance)
            begin
                cursor_x_reg <= adv_sum[8] ? CURSOR_MAX : adv_sum[7:0];
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + FAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            rd_reg  <= 8'd0;
        end
        if (cmd.read_capture)
        begin
            rd_reg <= rd_on ? f_q : 8'd0;
        end
        if (cmd.char_init)
        begin
            gaddr_reg <= glyph_base;
            line_reg  <= 6'd0;
        end
        if (cmd.row_capture)
        begin
            row_reg <= g_rd_on ? g_q : 16'd0;
            col_reg <= 5'd0;
        end
        if (cmd.col_step)
        begin
            col_reg <= col_reg + 5'd1;
        end
        if (cmd.row_step)
        begin
            line_reg  <= line_reg + 6'd1;
            gaddr_reg <= gaddr_reg + FRAME_IDX_W'(1);
        end
    end

    assign res.read_data  = rd_reg;
    assign res.cursor_col = cursor_x_reg;

endmodule

[src/mono_glyph_framebuffer_writer.sv]
// Top level of the monochrome glyph framebuffer writer.
// Depends on mgfw_pkg, mgfw_cfg, mgfw_ctrl, mgfw_dp.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------
//  request  | start in, busy out             | req   (req_t)
//  result   | done strobe, one cycle         | res   (res_t)
//  config   | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// A request is taken when start is high and busy is low; done follows once
// the request is complete. A pixel draw and a drawn character read each frame
// byte and then write it back, one pixel at a time on the frame memory port;
// a fill writes every byte. After reset the frame memory is cleared one byte
// per cycle, with busy high.
// The receiver cannot stall.
module mono_glyph_framebuffer_writer import mgfw_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int GLYPH_DEPTH   = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              done,
    output res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mgfw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mgfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    mgfw_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_DEPTH   (GLYPH_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

endmodule
